/* hdl/dcr_pkg.sv */
// dcr_pkg: shared constants for the DC removal / high-pass block.
// No dependencies; used by the interfaces, the serial multiplier and the top level.
package dcr_pkg;

	// fixed field widths
	localparam int RAW_W   = 12;   // converter reading on the input channel
	localparam int OUT_W   = 16;   // filtered sample on the output channel
	localparam int COEF_W  = 16;   // Q0.16 coefficients
	localparam int CFG_IDX_W = 2;  // config register index

	// defaults for top-level parameters
	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int FRACTION_BITS_DEF = 16;

	// extra integer bits of the high-pass state over the sample
	localparam int HP_GUARD = 8;

	// config register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_DC_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HP_ALPHA = 2'd1;
	localparam logic [COEF_W-1:0] DC_RATE_RST  = 16'd66;
	localparam logic [COEF_W-1:0] HP_ALPHA_RST = 16'd64225;

endpackage

/* hdl/dcr_if.sv */
// dcr_if: valid/ready channel interfaces for input and result transactions.
// Depends on dcr_pkg for the field widths.
interface dcr_in_if;
	logic                      valid;
	logic                      ready;
	logic [dcr_pkg::RAW_W-1:0] raw_sample;
	logic                      end_of_block;

	modport source(output valid, raw_sample, end_of_block, input ready);
	modport sink(input valid, raw_sample, end_of_block, output ready);
endinterface

interface dcr_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [dcr_pkg::OUT_W-1:0] filtered_sample;
	logic                             block_last;

	modport source(output valid, filtered_sample, block_last, input ready);
	modport sink(input valid, filtered_sample, block_last, output ready);
endinterface

/* hdl/dcr_sermul.sv */
// dcr_sermul: bit-serial signed x Q0.16 multiplier, result truncated toward zero.
// Walks the coefficient one bit per cycle, LSB first. Depends on dcr_pkg.
module dcr_sermul #(
	parameter int OPER_W = 37
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [OPER_W-1:0] operand,
	input  logic [dcr_pkg::COEF_W-1:0] coef,
	output logic                     done,
	output logic signed [OPER_W-1:0] product
);

	localparam int CNT_W = $clog2(dcr_pkg::COEF_W);

	logic                         run_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         neg_q;
	logic [OPER_W-1:0]            mag_q;
	logic [OPER_W-1:0]            acc_q;
	logic [dcr_pkg::COEF_W-1:0]   coef_q;
	logic [OPER_W:0]              acc_sum;
	logic [OPER_W-1:0]            oper_mag;

	// magnitude of the operand; the most negative value maps to its unsigned twin
	assign oper_mag = operand[OPER_W-1] ? OPER_W'(-operand) : operand;

	// one partial product per cycle, halved so truncation matches floor(m*c/2^16)
	assign acc_sum = {1'b0, acc_q} + (coef_q[0] ? {1'b0, mag_q} : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(dcr_pkg::COEF_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: coefficient shift register and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= operand[OPER_W-1];
			mag_q  <= oper_mag;
			coef_q <= coef;
			acc_q  <= '0;
		end else if (run_q) begin
			coef_q <= coef_q >> 1;
			acc_q  <= acc_sum[OPER_W:1];
		end
	end

	assign done    = done_q;
	assign product = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

/* hdl/audio_dc_removal_highpass.sv */
// audio_dc_removal_highpass: running DC estimate, DC subtraction and one-pole high-pass.
// Depends on dcr_pkg, dcr_if (channels) and dcr_sermul (shared serial multiplier).
//
//   channel     | dir | transaction payload               | handshake
//   ------------+-----+-----------------------------------+-------------------
//   sample_in   | in  | raw_sample[11:0], end_of_block    | valid/ready
//   sample_out  | out | filtered_sample[15:0], block_last | valid/ready
//   cfg         | in  | cfg_index, cfg_data[15:0]         | cfg_we, no stall
//
// An accepted sample runs two serial multiplies on one shared unit, the DC
// update and then the high-pass, with a difference step between them and a
// formatting step after: the result is loaded from the format state, and the
// next sample is taken only once the sequencer has returned to idle.
// A stalled output holds the finished sample in its register; the next sample
// is accepted meanwhile and waits before formatting until that register frees.
// Reset sets the DC estimate to midscale and clears the filter state.
module audio_dc_removal_highpass #(
	parameter int SAMPLE_BITS   = dcr_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = dcr_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dcr_in_if.sink                            sample_in,
	dcr_out_if.source                         sample_out,
	input  logic                              cfg_we,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dcr_pkg::COEF_W-1:0]        cfg_data
);

	localparam int DC_W   = SAMPLE_BITS + FRACTION_BITS;
	localparam int DIFF_W = DC_W + 1;
	localparam int PREV_W = DC_W + 2;
	localparam int HP_W   = DC_W + dcr_pkg::HP_GUARD;
	localparam int MUL_W  = HP_W + 1;
	localparam int INT_W  = HP_W - FRACTION_BITS;
	localparam int OUT_W  = dcr_pkg::OUT_W;
	localparam int RAW_W  = dcr_pkg::RAW_W;

	localparam logic [INT_W-1:0] POS_LIM = INT_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic [INT_W-1:0] NEG_LIM = INT_W'(2 ** (OUT_W - 1));

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                   state_q;
	logic [dcr_pkg::COEF_W-1:0]   dc_rate_q;
	logic [dcr_pkg::COEF_W-1:0]   hp_alpha_q;
	logic [DC_W-1:0]              dc_q;
	logic signed [HP_W-1:0]       hp_q;
	logic signed [PREV_W-1:0]     prev_q;
	logic [SAMPLE_BITS-1:0]       raw_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic signed [OUT_W-1:0]      out_sample_q;
	logic                         out_last_q;

	logic                         in_acc;
	logic                         out_free;
	logic [RAW_W+SAMPLE_BITS-1:0] raw_ext;
	logic [SAMPLE_BITS-1:0]       raw_in;
	logic signed [DIFF_W-1:0]     err_in;
	logic signed [DIFF_W-1:0]     diff;
	logic signed [MUL_W-1:0]      hp_sum;
	logic signed [DIFF_W-1:0]     dc_next;
	logic signed [HP_W-1:0]       hp_next;
	logic                         mul_start;
	logic signed [MUL_W-1:0]      mul_oper;
	logic [dcr_pkg::COEF_W-1:0]   mul_coef;
	logic                         mul_done;
	logic signed [MUL_W-1:0]      mul_prod;
	logic [HP_W-1:0]              hp_mag;
	logic [INT_W-1:0]             hp_int;
	logic signed [OUT_W-1:0]      out_fmt;

	// handshakes
	assign in_acc   = sample_in.valid && sample_in.ready;
	assign out_free = !out_valid_q || sample_out.ready;
	assign sample_in.ready = (state_q == ST_IDLE);

	// low SAMPLE_BITS bits of the reading
	assign raw_ext = {{SAMPLE_BITS{1'b0}}, sample_in.raw_sample};
	assign raw_in  = raw_ext[SAMPLE_BITS-1:0];

	// raw - dc for the tracking update, and raw - new dc for the filter input
	assign err_in = $signed({1'b0, raw_in, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, dc_q});
	assign diff   = $signed({1'b0, raw_q, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, dc_q});
	assign hp_sum = MUL_W'(hp_q) + MUL_W'(diff) - MUL_W'(prev_q);

	// shared multiplier operand select
	assign mul_start = in_acc || (state_q == ST_SUM);
	assign mul_oper  = (state_q == ST_IDLE) ? MUL_W'(err_in) : hp_sum;
	assign mul_coef  = (state_q == ST_IDLE) ? dc_rate_q : hp_alpha_q;

	dcr_sermul #(
		.OPER_W(MUL_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.operand(mul_oper),
		.coef   (mul_coef),
		.done   (mul_done),
		.product(mul_prod)
	);

	// dc update never leaves the sample range
	assign dc_next = $signed({1'b0, dc_q}) + mul_prod[DIFF_W-1:0];

	// saturate the high-pass product to the state width
	always_comb begin
		if (mul_prod[MUL_W-1] != mul_prod[MUL_W-2]) begin
			hp_next = mul_prod[MUL_W-1] ? {1'b1, {(HP_W-1){1'b0}}} : {1'b0, {(HP_W-1){1'b1}}};
		end else begin
			hp_next = mul_prod[HP_W-1:0];
		end
	end

	// integer part toward zero, clamped to 16 bits
	assign hp_mag = hp_q[HP_W-1] ? HP_W'(-hp_q) : hp_q;
	assign hp_int = hp_mag[HP_W-1:FRACTION_BITS];
	always_comb begin
		if (hp_q[HP_W-1]) begin
			out_fmt = (hp_int >= NEG_LIM) ? {1'b1, {(OUT_W-1){1'b0}}} : -$signed(hp_int[OUT_W-1:0]);
		end else begin
			out_fmt = (hp_int > POS_LIM) ? {1'b0, {(OUT_W-1){1'b1}}} : $signed(hp_int[OUT_W-1:0]);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_rate_q  <= dcr_pkg::DC_RATE_RST;
			hp_alpha_q <= dcr_pkg::HP_ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dcr_pkg::REG_DC_RATE:  dc_rate_q  <= cfg_data;
				dcr_pkg::REG_HP_ALPHA: hp_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dc_q        <= DC_W'(1) << (DC_W - 1);
			hp_q        <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded from the format state, cleared once taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (sample_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (mul_done) begin
						dc_q    <= dc_next[DC_W-1:0];
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					prev_q  <= PREV_W'(diff);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (mul_done) begin
						hp_q    <= hp_next;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample payload held through the item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q  <= raw_in;
			last_q <= sample_in.end_of_block;
		end
		if (state_q == ST_OUT && out_free) begin
			out_sample_q <= out_fmt;
			out_last_q   <= last_q;
		end
	end

	assign sample_out.valid           = out_valid_q;
	assign sample_out.filtered_sample = out_sample_q;
	assign sample_out.block_last      = out_last_q;

	// multiplier completes only while the sequencer waits for it
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL1 || state_q == ST_MUL2))
		else $error("multiplier done outside a multiply state");

	// an accepted sample starts the DC multiply
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL1))
		else $error("accepted sample did not start the DC multiply");

	// a new result is only loaded from the format state
	a_out_from_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result loaded outside the format state");

endmodule
